/* sv/pbd_pkg.sv */
package pbd_pkg;

	// width of the output_length register
	localparam int unsigned CFG_LEN_W = 24;

	// headers at or below this value announce a literal run
	localparam logic [7:0] HDR_LIMIT = 8'h7f;

	// command queue between front and back
	localparam int unsigned CMD_DEPTH = 2;

	localparam logic [2:0] REG_OUTPUT_LENGTH = 3'd0;

	// one command: a byte, how many times to put it, and whether it ends the stream
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] count;
		logic       last;
	} pbd_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pbd_q_status_t;

endpackage

/* sv/pbd_front.sv */
module pbd_front #(
	parameter int unsigned LENGTH_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pbd_pkg::CFG_LEN_W-1:0] len_cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_byte,
	input  pbd_pkg::pbd_q_status_t        q_status,
	output logic                          push,
	output pbd_pkg::pbd_cmd_t             push_cmd
);

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_LITERAL = 3'b010,
		PH_REPEAT  = 3'b100
	} pbd_phase_t;

	localparam int unsigned PW = LENGTH_BITS + 1;

	pbd_phase_t      phase_q;
	logic [7:0]      literal_left_q;
	logic [7:0]      repeat_len_q;
	logic [PW-1:0]   produced_q;

	logic [LENGTH_BITS-1:0] len_lo;
	logic [PW-1:0]          len_eff;
	logic [PW-1:0]          lit_sum;
	logic [PW-1:0]          rep_sum;
	logic                   lit_end;
	logic                   rep_end;
	logic [7:0]             rep_cnt;
	logic                   accept;

	// zero length means the full 2^LENGTH_BITS
	assign len_lo  = LENGTH_BITS'(len_cfg);
	assign len_eff = (len_lo == '0) ? {1'b1, {LENGTH_BITS{1'b0}}} : {1'b0, len_lo};

	assign lit_sum = produced_q + PW'(1);
	assign rep_sum = produced_q + PW'(repeat_len_q);
	assign lit_end = lit_sum >= len_eff;
	assign rep_end = rep_sum >= len_eff;

	// truncated run: whatever is left of the stream, at least one byte
	always_comb begin
		if (produced_q >= len_eff) begin
			rep_cnt = 8'd1;
		end else begin
			rep_cnt = 8'(len_eff - produced_q);
		end
	end

	// headers never go to the queue
	assign in_ready = (phase_q == PH_HEADER) || !q_status.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (phase_q != PH_HEADER);

	always_comb begin
		push_cmd.data = in_byte;
		if (phase_q == PH_LITERAL) begin
			push_cmd.count = 8'd1;
			push_cmd.last  = lit_end;
		end else begin
			push_cmd.count = rep_end ? rep_cnt : repeat_len_q;
			push_cmd.last  = rep_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			literal_left_q <= '0;
			repeat_len_q   <= '0;
			produced_q     <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_LITERAL: begin
					if (lit_end) begin
						phase_q        <= PH_HEADER;
						literal_left_q <= '0;
						repeat_len_q   <= '0;
						produced_q     <= '0;
					end else begin
						produced_q     <= lit_sum;
						literal_left_q <= literal_left_q - 8'd1;
						if (literal_left_q <= 8'd1) begin
							phase_q <= PH_HEADER;
						end
					end
				end
				PH_REPEAT: begin
					phase_q      <= PH_HEADER;
					repeat_len_q <= '0;
					if (rep_end) begin
						literal_left_q <= '0;
						produced_q     <= '0;
					end else begin
						produced_q <= rep_sum;
					end
				end
				default: begin
					if (in_byte <= pbd_pkg::HDR_LIMIT) begin
						literal_left_q <= in_byte + 8'd1;
						phase_q        <= PH_LITERAL;
					end else begin
						repeat_len_q <= (8'h00 - in_byte) + 8'd1;
						phase_q      <= PH_REPEAT;
					end
				end
			endcase
		end
	end

	a_cmd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_cmd.count != 8'd0)
		else $error("command with zero count");

	a_run_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(push && phase_q == PH_REPEAT && !push_cmd.last) |-> push_cmd.count == repeat_len_q)
		else $error("untruncated run lost bytes");

endmodule

/* sv/pbd_cmd_fifo.sv */
module pbd_cmd_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pbd_pkg::pbd_cmd_t      push_cmd,
	input  logic                   pop,
	output pbd_pkg::pbd_cmd_t      pop_cmd,
	output pbd_pkg::pbd_q_status_t status
);

	localparam int unsigned DEPTH = pbd_pkg::CMD_DEPTH;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	pbd_pkg::pbd_cmd_t mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     fill_q;

	assign status.full  = (fill_q == CW'(DEPTH));
	assign status.empty = (fill_q == '0);
	assign pop_cmd      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty))
		else $error("command queue underflow");

endmodule

/* sv/pbd_back.sv */
module pbd_back #(
	parameter int unsigned OUT_BYTES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pbd_pkg::pbd_cmd_t                   q_cmd,
	input  pbd_pkg::pbd_q_status_t              q_status,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [8*OUT_BYTES-1:0]              out_word,
	output logic [$clog2(OUT_BYTES+1)-1:0]      valid_bytes,
	output logic                                last
);

	localparam int unsigned WW   = 8 * OUT_BYTES;
	localparam int unsigned CNTW = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
	localparam int unsigned VBW  = $clog2(OUT_BYTES + 1);

	logic              cur_valid_q;
	pbd_pkg::pbd_cmd_t cur_q;
	logic [WW-1:0]     acc_word_q;
	logic [CNTW-1:0]   acc_cnt_q;

	logic              out_valid_q;
	logic [WW-1:0]     out_word_q;
	logic [VBW-1:0]    out_vb_q;
	logic              out_last_q;

	logic              final_byte;
	logic              emit;
	logic              slot_free;
	logic              step;
	logic [WW-1:0]     next_word;

	assign final_byte = (cur_q.count == 8'd1);
	assign emit       = (acc_cnt_q == CNTW'(OUT_BYTES - 1)) || (final_byte && cur_q.last);
	assign slot_free  = !out_valid_q || out_ready;
	assign step       = cur_valid_q && (!emit || slot_free);
	assign pop        = !q_status.empty && (!cur_valid_q || (step && final_byte));

	// drop the byte into its lane
	always_comb begin
		next_word = acc_word_q;
		for (int i = 0; i < OUT_BYTES; i++) begin
			if (acc_cnt_q == CNTW'(i)) begin
				next_word[8*i +: 8] = cur_q.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_cmd;
		end else if (step) begin
			cur_q.count <= cur_q.count - 8'd1;
		end
		if (step && emit) begin
			out_word_q <= next_word;
			out_vb_q   <= VBW'(acc_cnt_q) + VBW'(1);
			out_last_q <= final_byte && cur_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			acc_word_q  <= '0;
			acc_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (step && final_byte) begin
				cur_valid_q <= 1'b0;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				if (emit) begin
					acc_word_q  <= '0;
					acc_cnt_q   <= '0;
					out_valid_q <= 1'b1;
				end else begin
					acc_word_q <= next_word;
					acc_cnt_q  <= acc_cnt_q + CNTW'(1);
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_word    = out_word_q;
	assign valid_bytes = out_vb_q;
	assign last        = out_last_q;

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit) |=> acc_cnt_q == '0)
		else $error("accumulator not cleared after word");

	a_vb_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_vb_q != '0)
		else $error("word with no valid bytes");

	a_no_lost_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(step && emit))
		else $error("word overwritten while held");

endmodule

/* sv/packbits_byte_decoder.sv */
// PackBits byte decoder. Packed bytes enter one item per cycle on s_* while
// s_tready is high; a header 0..127 copies the next header+1 bytes, a header
// 128..255 repeats the next byte (256-header)+1 times. Unpacked bytes leave
// OUT_BYTES to a word on m_*, first byte lowest, with the lane count in tuser
// and tlast on the word that reaches output_length (APB register at address 0,
// reset 1, 0 meaning 2^LENGTH_BITS). The last word of a stream may be short, an
// overshooting run is cut, and the next byte starts a new stream. The back end
// puts out one byte per cycle unless a finished word is held up, so a repeat run
// of up to 129 bytes occupies it, and the two-entry command queue lets up to two
// data bytes be taken meanwhile before s_tready drops. Output words sit in a
// register, so the decoder fills the next word while a word waits on m_tready.
module packbits_byte_decoder #(
	parameter int unsigned OUT_BYTES   = 4,
	parameter int unsigned LENGTH_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,

	// packed input
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [7:0] packed_byte

	// unpacked output
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [8*OUT_BYTES-1:0]             m_tdata,   // out_word, byte 0 lowest
	output logic [$clog2(OUT_BYTES+1)-1:0]     m_tuser,   // valid_bytes
	output logic                               m_tlast,   // last

	// register port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	logic [pbd_pkg::CFG_LEN_W-1:0] output_length_q;

	pbd_pkg::pbd_cmd_t      push_cmd;
	pbd_pkg::pbd_cmd_t      pop_cmd;
	pbd_pkg::pbd_q_status_t q_status;
	logic                   push;
	logic                   pop;

	// registers: only output_length, at byte address 0; bits 1:0 ignored
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_length_q <= pbd_pkg::CFG_LEN_W'(1);
		end else if (psel && penable && pwrite && pready
		             && ({paddr[2], 2'b00} == pbd_pkg::REG_OUTPUT_LENGTH)) begin
			output_length_q <= pwdata[pbd_pkg::CFG_LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if ({paddr[2], 2'b00} == pbd_pkg::REG_OUTPUT_LENGTH) begin
			prdata = 32'(output_length_q);
		end
	end

	// front: header parsing, length tracking, run truncation
	pbd_front #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.len_cfg  (output_length_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pbd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.status   (q_status)
	);

	// back: byte expansion and word packing
	pbd_back #(
		.OUT_BYTES (OUT_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_cmd       (pop_cmd),
		.q_status    (q_status),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_word    (m_tdata),
		.valid_bytes (m_tuser),
		.last        (m_tlast)
	);

endmodule
